/* src/typed_register_bytecode_executor_top_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef TYPED_REGISTER_BYTECODE_EXECUTOR_TOP_MACROS_SVH
`define TYPED_REGISTER_BYTECODE_EXECUTOR_TOP_MACROS_SVH

// Implication checked every rising clock edge outside reset.
`define TRBE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define TRBE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/trbe_pkg.sv */
`default_nettype none
package trbe_pkg;
    localparam int REG_DEPTH = 256;
    localparam int RIDX_W = $clog2(REG_DEPTH);
    localparam int EPOCH_W = 8;

    typedef logic [1:0] tag_t;
    localparam tag_t TY_NONE = 2'd0;
    localparam tag_t TY_U64  = 2'd1;
    localparam tag_t TY_I64  = 2'd2;
    localparam tag_t TY_BOOL = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_RUN  = 3'd0;
    localparam status_t ST_CONT = 3'd1;
    localparam status_t ST_SUSP = 3'd2;
    localparam status_t ST_TERM = 3'd3;
    localparam status_t ST_BAD  = 3'd4;

    localparam logic [7:0] OP_NOP = 8'd0, OP_CONST = 8'd1, OP_MOVE = 8'd2, OP_ADD = 8'd3,
        OP_SUB = 8'd4, OP_MUL = 8'd5, OP_AND = 8'd6, OP_OR = 8'd7, OP_XOR = 8'd8,
        OP_NOT = 8'd9, OP_EQ = 8'd10, OP_ULT = 8'd11, OP_SLT = 8'd12, OP_LOAD = 8'd13,
        OP_STORE = 8'd14, OP_JUMP = 8'd15, OP_BRZ = 8'd16, OP_CONT = 8'd17,
        OP_SUSP = 8'd18, OP_TERM = 8'd19;

    localparam logic [2:0] CFG_ICOUNT = 3'd0, CFG_RCOUNT = 3'd1, CFG_FLIMIT = 3'd2,
        CFG_SKFIRST = 3'd3, CFG_SKLAST = 3'd4;

    localparam logic [15:0] NO_PAYLOAD_REG = 16'hFFFF;

    // register file entry: epoch, tag, value
    localparam int ENT_W = EPOCH_W + 2 + 64;

    typedef struct packed {
        logic         valid;
        logic [RIDX_W-1:0] idx;
        logic [ENT_W-1:0]  data;
    } rf_wr_t;
endpackage
`default_nettype wire

/* src/trbe_ram.sv */
`default_nettype none
module trbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/typed_register_bytecode_executor_top.sv */
// Typed register bytecode executor.
// Input channel s_*: one request per instruction. A start request (req_type 0)
// whose pc is below icount sets the pc and clears the register file; execute requests
// supply the instruction at the reported next_pc. Result channel m_*: one result per
// request, giving status, next pc, action fields and any frame store.
// Configuration channel cfg_*: index and data; write only while idle.
// Throughput: one request per cycle unless a waiting result or a sweep holds the
// pipeline. A request passes the register file read, then execute into the output register.
// Register file is two single-port-read memories (operands a and b) with a
// registered read and forwarding from the two writes that the read can miss.
// A start that sets the pc clears the file by advancing an epoch; entries with an
// old epoch read as none/zero. Every 255 such starts the block sweeps the memories
// to reset stale epochs, holding the whole pipeline and taking no requests meanwhile;
// the same sweep runs after reset. Configuration writes are accepted throughout.
// While a result waits with m_ready low the pipeline holds and s_ready is low.
`default_nettype none
module typed_register_bytecode_executor_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_opcode,
    input  wire logic [7:0]  s_type_tag,
    input  wire logic [15:0] s_dest_reg,
    input  wire logic [15:0] s_src_a,
    input  wire logic [15:0] s_src_b,
    input  wire logic [63:0] s_immediate,
    input  wire logic [63:0] s_frame_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_next_pc,
    output logic [31:0]      m_continuation_out,
    output logic [15:0]      m_suspend_kind_out,
    output logic [63:0]      m_payload,
    output logic             m_store_enable,
    output logic [31:0]      m_store_offset,
    output logic [63:0]      m_store_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import trbe_pkg::*;
    `include "typed_register_bytecode_executor_top_macros.svh"

    logic [31:0] icount_reg, flimit_reg;
    logic [8:0]  rcount_reg;
    logic [15:0] skf_reg, skl_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icount_reg <= 32'd1;
            rcount_reg <= 9'd0;
            flimit_reg <= 32'd0;
            skf_reg    <= 16'd1;
            skl_reg    <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ICOUNT:  icount_reg <= cfg_data;
                CFG_RCOUNT:  rcount_reg <= cfg_data[8:0];
                CFG_FLIMIT:  flimit_reg <= cfg_data;
                CFG_SKFIRST: skf_reg <= cfg_data[15:0];
                CFG_SKLAST:  skl_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline: stage 1 (read issued), stage 2 (execute), output register.
    logic s1_v_reg, s2_v_reg;
    logic s1_req_reg; logic [7:0] s1_op_reg, s1_ty_reg;
    logic [15:0] s1_d_reg, s1_a_reg, s1_b_reg;
    logic [63:0] s1_imm_reg, s1_fw_reg;
    logic        adv, out_free;
    logic        sweep_reg;
    logic [RIDX_W:0] sweep_cnt_reg;

    // hold every stage while the sweep runs or a result waits with m_ready low
    assign out_free = !m_valid || m_ready;
    assign adv = out_free && !sweep_reg;
    assign s_ready = adv;

    logic [RIDX_W-1:0] ra_a, ra_b;
    logic [ENT_W-1:0]  rd_a, rd_b;
    rf_wr_t wr, wr_d1;

    assign ra_a = s_src_a[RIDX_W-1:0];
    assign ra_b = s_src_b[RIDX_W-1:0];

    logic [ENT_W-1:0] wdata_mem;
    logic [RIDX_W-1:0] waddr_mem;
    logic we_mem;
    assign we_mem    = sweep_reg || wr.valid;
    assign waddr_mem = sweep_reg ? sweep_cnt_reg[RIDX_W-1:0] : wr.idx;
    assign wdata_mem = sweep_reg ? '0 : wr.data;

    // Read ports sit on the input; a held stage must keep its read data.
    logic [RIDX_W-1:0] rda, rdb;
    assign rda = (s_valid && s_ready) ? ra_a : s1_a_reg[RIDX_W-1:0];
    assign rdb = (s_valid && s_ready) ? ra_b : s1_b_reg[RIDX_W-1:0];

    trbe_ram #(.WIDTH(ENT_W), .DEPTH(REG_DEPTH)) u_ram_a (
        .aclk(aclk), .we(we_mem), .waddr(waddr_mem), .wdata(wdata_mem),
        .raddr(rda), .rdata(rd_a));
    trbe_ram #(.WIDTH(ENT_W), .DEPTH(REG_DEPTH)) u_ram_b (
        .aclk(aclk), .we(we_mem), .waddr(waddr_mem), .wdata(wdata_mem),
        .raddr(rdb), .rdata(rd_b));

    // The read happens the cycle the request enters stage 1 (or re-reads
    // while held). A write in that same cycle is missed: forward it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            s1_req_reg <= s_req_type; s1_op_reg <= s_opcode; s1_ty_reg <= s_type_tag;
            s1_d_reg <= s_dest_reg; s1_a_reg <= s_src_a; s1_b_reg <= s_src_b;
            s1_imm_reg <= s_immediate; s1_fw_reg <= s_frame_word;
        end
        wr_d1 <= wr;
    end

    logic [EPOCH_W-1:0] epoch_reg;
    logic [ENT_W-1:0] ea, eb;
    always_comb begin
        ea = rd_a;
        eb = rd_b;
        if (wr_d1.valid && wr_d1.idx == s1_a_reg[RIDX_W-1:0]) ea = wr_d1.data;
        if (wr_d1.valid && wr_d1.idx == s1_b_reg[RIDX_W-1:0]) eb = wr_d1.data;
        if (wr.valid && wr.idx == s1_a_reg[RIDX_W-1:0]) ea = wr.data;
        if (wr.valid && wr.idx == s1_b_reg[RIDX_W-1:0]) eb = wr.data;
    end

    // stage 1 -> stage 2: operands resolved (epoch mismatch reads as cleared)
    logic [1:0]  s2_ta_reg, s2_tb_reg;
    logic [63:0] s2_va_reg, s2_vb_reg;
    logic s2_req_reg; logic [7:0] s2_op_reg, s2_ty_reg;
    logic [15:0] s2_d_reg, s2_a_reg, s2_b_reg;
    logic [63:0] s2_imm_reg, s2_fw_reg;
    logic start_clr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= s1_v_reg;
        end
        if (adv) begin
            if (ea[ENT_W-1 -: EPOCH_W] == epoch_reg && !start_clr) begin
                s2_ta_reg <= ea[65:64]; s2_va_reg <= ea[63:0];
            end else begin
                s2_ta_reg <= TY_NONE; s2_va_reg <= '0;
            end
            if (eb[ENT_W-1 -: EPOCH_W] == epoch_reg && !start_clr) begin
                s2_tb_reg <= eb[65:64]; s2_vb_reg <= eb[63:0];
            end else begin
                s2_tb_reg <= TY_NONE; s2_vb_reg <= '0;
            end
            s2_req_reg <= s1_req_reg; s2_op_reg <= s1_op_reg; s2_ty_reg <= s1_ty_reg;
            s2_d_reg <= s1_d_reg; s2_a_reg <= s1_a_reg; s2_b_reg <= s1_b_reg;
            s2_imm_reg <= s1_imm_reg; s2_fw_reg <= s1_fw_reg;
        end
    end

    // Execute stage.
    logic [31:0] pc_reg;
    logic        run_reg;
    logic [31:0] pc_next;
    logic        run_next, ok;
    logic [2:0]  st;
    logic [63:0] res, pay;
    logic [1:0]  rt;
    logic        wen;
    logic [31:0] cont, sto;
    logic [15:0] kind;
    logic        sten;
    logic [63:0] std;
    logic        ta_ok, tb_ok, a_ok, b_ok, d_ok, ty_sc, fr_ok, imm_lt;
    logic [8:0]  rlim;
    logic        epoch_bump;
    logic [63:0] prod, pp_ll;
    logic [31:0] pp_lh, pp_hl;
    logic [31:0] frem;

    assign rlim  = (rcount_reg > 9'(REG_DEPTH)) ? 9'(REG_DEPTH) : rcount_reg;
    assign ty_sc = s2_ty_reg == 8'(TY_U64) || s2_ty_reg == 8'(TY_I64) ||
                   s2_ty_reg == 8'(TY_BOOL);
    assign a_ok  = {7'd0, s2_a_reg} < {7'd0, rlim, 7'd0} >> 7;
    assign b_ok  = {7'd0, s2_b_reg} < {7'd0, rlim, 7'd0} >> 7;
    assign d_ok  = {7'd0, s2_d_reg} < {7'd0, rlim, 7'd0} >> 7;
    assign ta_ok = ty_sc && a_ok && {6'd0, s2_ta_reg} == s2_ty_reg;
    assign tb_ok = ty_sc && b_ok && {6'd0, s2_tb_reg} == s2_ty_reg;
    assign frem  = flimit_reg - s2_imm_reg[31:0];
    assign fr_ok = s2_imm_reg[63:32] == 32'd0 && s2_imm_reg[31:0] <= flimit_reg &&
                   frem >= 32'd8;
    assign imm_lt = s2_imm_reg < {32'd0, icount_reg};

    // low 64 bits of the product from three 32x32 partial products
    assign pp_ll = 64'(s2_va_reg[31:0]) * 64'(s2_vb_reg[31:0]);
    assign pp_lh = s2_va_reg[31:0] * s2_vb_reg[63:32];
    assign pp_hl = s2_va_reg[63:32] * s2_vb_reg[31:0];
    assign prod  = pp_ll + {pp_lh + pp_hl, 32'd0};

    always_comb begin
        ok = 1'b1; wen = 1'b0; res = '0; rt = s2_ty_reg[1:0];
        st = ST_RUN; cont = '0; kind = '0; pay = '0; sten = 1'b0; sto = '0; std = '0;
        pc_next = pc_reg + 32'd1;
        case (s2_op_reg)
            OP_NOP: ok = s2_ty_reg == 8'(TY_NONE);
            OP_CONST: begin
                ok = ty_sc && d_ok && !(s2_ty_reg == 8'(TY_BOOL) && s2_imm_reg > 64'd1);
                wen = 1'b1; res = s2_imm_reg;
            end
            OP_MOVE: begin
                ok = ta_ok && d_ok; wen = 1'b1; res = s2_va_reg;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_EQ, OP_ULT, OP_SLT: begin
                ok = ta_ok && tb_ok && d_ok; wen = 1'b1;
                case (s2_op_reg)
                    OP_ADD: res = s2_va_reg + s2_vb_reg;
                    OP_SUB: res = s2_va_reg - s2_vb_reg;
                    OP_MUL: res = prod;
                    OP_AND: res = s2_va_reg & s2_vb_reg;
                    OP_OR:  res = s2_va_reg | s2_vb_reg;
                    OP_XOR: res = s2_va_reg ^ s2_vb_reg;
                    OP_EQ:  res = {63'd0, s2_va_reg == s2_vb_reg};
                    OP_ULT: res = {63'd0, s2_va_reg < s2_vb_reg};
                    default: res = {63'd0, $signed(s2_va_reg) < $signed(s2_vb_reg)};
                endcase
                if (s2_op_reg == OP_EQ || s2_op_reg == OP_ULT || s2_op_reg == OP_SLT)
                    rt = TY_BOOL;
                if ((s2_op_reg == OP_ADD || s2_op_reg == OP_SUB || s2_op_reg == OP_MUL) &&
                    s2_ty_reg == 8'(TY_BOOL)) ok = 1'b0;
                if (s2_op_reg == OP_ULT && s2_ty_reg != 8'(TY_U64)) ok = 1'b0;
                if (s2_op_reg == OP_SLT && s2_ty_reg != 8'(TY_I64)) ok = 1'b0;
            end
            OP_NOT: begin
                ok = ta_ok && d_ok; wen = 1'b1;
                res = (s2_ty_reg == 8'(TY_BOOL)) ? {63'd0, s2_va_reg == 64'd0} : ~s2_va_reg;
            end
            OP_LOAD: begin
                ok = fr_ok && ty_sc && d_ok &&
                     !(s2_ty_reg == 8'(TY_BOOL) && s2_fw_reg > 64'd1);
                wen = 1'b1; res = s2_fw_reg;
            end
            OP_STORE: begin
                ok = fr_ok && ta_ok;
                sten = 1'b1; sto = s2_imm_reg[31:0]; std = s2_va_reg;
            end
            OP_JUMP: begin
                ok = s2_ty_reg == 8'(TY_NONE) && imm_lt;
                pc_next = s2_imm_reg[31:0];
            end
            OP_BRZ: begin
                ok = ta_ok && imm_lt;
                if (s2_va_reg == 64'd0) pc_next = s2_imm_reg[31:0];
            end
            OP_CONT: begin
                ok = s2_ty_reg == 8'(TY_NONE) && s2_imm_reg[63:32] == 32'd0;
                st = ST_CONT; cont = s2_imm_reg[31:0];
            end
            OP_SUSP: begin
                ok = s2_ty_reg == 8'(TY_NONE) && s2_a_reg >= skf_reg &&
                     s2_a_reg <= skl_reg && s2_imm_reg[63:32] == 32'd0 &&
                     (s2_b_reg == NO_PAYLOAD_REG || (b_ok && s2_tb_reg == TY_U64));
                st = ST_SUSP; kind = s2_a_reg; cont = s2_imm_reg[31:0];
                pay = (s2_b_reg == NO_PAYLOAD_REG) ? 64'd0 : s2_vb_reg;
            end
            OP_TERM: begin
                ok = s2_ty_reg == 8'(TY_NONE);
                st = ST_TERM; pay = s2_imm_reg;
            end
            default: ok = 1'b0;
        endcase
    end

    logic [2:0] o_st; logic [31:0] o_pc, o_cont, o_sto; logic [15:0] o_kind;
    logic [63:0] o_pay, o_std; logic o_sten;
    logic do_ex, do_wr;

    assign do_ex = s2_v_reg && adv;

    always_comb begin
        run_next = run_reg; o_st = ST_BAD; o_pc = '0; o_cont = '0; o_kind = '0;
        o_pay = '0; o_sten = 1'b0; o_sto = '0; o_std = '0; do_wr = 1'b0;
        epoch_bump = 1'b0;
        if (!s2_req_reg) begin
            if (!imm_lt) begin
                run_next = 1'b0;
            end else begin
                run_next = 1'b1; o_st = ST_RUN; o_pc = s2_imm_reg[31:0]; epoch_bump = 1'b1;
            end
        end else if (!run_reg || pc_reg >= icount_reg || !ok) begin
            run_next = 1'b0;
        end else begin
            do_wr = wen;
            o_sten = sten; o_sto = sto; o_std = std;
            if (st != ST_RUN) begin
                run_next = 1'b0; o_st = st; o_cont = cont; o_kind = kind; o_pay = pay;
            end else if (pc_next >= icount_reg) begin
                run_next = 1'b0;
            end else begin
                o_st = ST_RUN; o_pc = pc_next;
            end
        end
    end

    logic [31:0] pc_upd;
    assign pc_upd = !s2_req_reg ? s2_imm_reg[31:0] : pc_next;

    always_comb begin
        wr.valid = do_ex && do_wr;
        wr.idx   = s2_d_reg[RIDX_W-1:0];
        wr.data  = {epoch_reg, rt, res};
    end

    // A start in stage 2 clears; stage 1 reads taken before it must be voided.
    assign start_clr = do_ex && epoch_bump;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0; pc_reg <= '0; m_valid <= 1'b0;
            epoch_reg <= EPOCH_W'(1); sweep_reg <= 1'b1; sweep_cnt_reg <= '0;
        end else begin
            // one extra pass over entry 0 so a held read sees every cleared entry
            if (sweep_reg) begin
                sweep_cnt_reg <= sweep_cnt_reg + (RIDX_W+1)'(1);
                if (sweep_cnt_reg == (RIDX_W+1)'(REG_DEPTH)) sweep_reg <= 1'b0;
            end
            if (out_free) m_valid <= do_ex;
            if (do_ex) begin
                run_reg <= run_next;
                if (run_next && (o_st == ST_RUN)) pc_reg <= pc_upd;
                if (epoch_bump) begin
                    if (epoch_reg == {EPOCH_W{1'b1}}) begin
                        epoch_reg <= EPOCH_W'(1); sweep_reg <= 1'b1; sweep_cnt_reg <= '0;
                    end else begin
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_ex) begin
            m_status <= o_st; m_next_pc <= o_pc; m_continuation_out <= o_cont;
            m_suspend_kind_out <= o_kind; m_payload <= o_pay; m_store_enable <= o_sten;
            m_store_offset <= o_sto; m_store_data <= o_std;
        end
    end

    `TRBE_ASSERT_IMP(a_no_accept_in_sweep, aclk, aresetn, sweep_reg, !s_ready,
        "request accepted during sweep")
    `TRBE_ASSERT_IMP(a_no_write_in_sweep, aclk, aresetn, sweep_reg, !wr.valid,
        "register write during sweep")
    `TRBE_ASSERT_NXT(a_bad_stops, aclk, aresetn, do_ex && o_st != ST_RUN, !run_reg,
        "run continues after non-running result")
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trbe_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic        req;
        logic [7:0]  op;
        logic [7:0]  ty;
        logic [15:0] d;
        logic [15:0] a;
        logic [15:0] b;
        logic [63:0] imm;
        logic [63:0] fw;
    } instr_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] npc;
        logic [31:0] cont;
        logic [15:0] kind;
        logic [63:0] pay;
        logic        sen;
        logic [31:0] soff;
        logic [63:0] sdat;
    } outcome_t;

    class run_tracker;
        tag_t        tg[REG_DEPTH];
        logic [63:0] vl[REG_DEPTH];
        logic [31:0] pc;
        bit          active;
        logic [31:0] icount;
        logic [8:0]  rcount;
        logic [31:0] flimit;
        logic [15:0] skf;
        logic [15:0] skl;
        outcome_t    pending_outcomes[$];
        int          mismatches;
        int          results_seen;

        function new();
            clear_file();
            pc = 0;
            active = 0;
            icount = 1;
            rcount = 0;
            flimit = 0;
            skf = 1;
            skl = 1;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void clear_file();
            foreach (tg[i]) begin
                tg[i] = TY_NONE;
                vl[i] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_ICOUNT:  icount = v;
                CFG_RCOUNT:  rcount = v[8:0];
                CFG_FLIMIT:  flimit = v;
                CFG_SKFIRST: skf = v[15:0];
                CFG_SKLAST:  skl = v[15:0];
                default: ;
            endcase
        endfunction

        function bit scalar(logic [7:0] t);
            return t == TY_U64 || t == TY_I64 || t == TY_BOOL;
        endfunction

        function bit reg_ok(logic [15:0] i);
            return i < rcount && i < REG_DEPTH;
        endfunction

        function bit src_ok(logic [15:0] i, logic [7:0] t);
            return scalar(t) && reg_ok(i) && tg[i[7:0]] == t[1:0];
        endfunction

        function bit frame_ok(logic [63:0] off);
            logic [63:0] lim;
            lim = {32'b0, flimit};
            return off <= lim && 64'd8 <= lim - off;
        endfunction

        function bit wr(logic [15:0] i, logic [7:0] t, logic [63:0] v);
            if (!reg_ok(i) || !scalar(t))
                return 0;
            tg[i[7:0]] = t[1:0];
            vl[i[7:0]] = v;
            return 1;
        endfunction

        function bit binop(logic [7:0] op, logic [7:0] t, logic [15:0] d,
                           logic [15:0] a, logic [15:0] b);
            logic [63:0] x, y, r;
            logic [7:0]  rt;
            if (!src_ok(a, t) || !src_ok(b, t))
                return 0;
            x = vl[a[7:0]];
            y = vl[b[7:0]];
            rt = t;
            case (op)
                OP_ADD: r = x + y;
                OP_SUB: r = x - y;
                OP_MUL: r = x * y;
                OP_AND: r = x & y;
                OP_OR:  r = x | y;
                OP_XOR: r = x ^ y;
                OP_EQ:  begin r = {63'b0, x == y}; rt = TY_BOOL; end
                OP_ULT: begin r = {63'b0, x < y}; rt = TY_BOOL; end
                default: begin r = {63'b0, $signed(x) < $signed(y)}; rt = TY_BOOL; end
            endcase
            return wr(d, rt, r);
        endfunction

        function void note(instr_t it);
            outcome_t    o;
            bit          ok;
            logic [31:0] npc;
            logic [2:0]  st;
            logic [63:0] va;
            o = '0;
            if (it.req == 1'b0) begin
                if (it.imm >= {32'b0, icount}) begin
                    active = 0;
                    o.st = ST_BAD;
                end else begin
                    clear_file();
                    pc = it.imm[31:0];
                    active = 1;
                    o.st = ST_RUN;
                    o.npc = pc;
                end
                pending_outcomes.push_back(o);
                return;
            end
            if (!active || pc >= icount) begin
                active = 0;
                o.st = ST_BAD;
                pending_outcomes.push_back(o);
                return;
            end
            npc = pc + 32'd1;
            st = ST_RUN;
            va = vl[it.a[7:0]];
            case (it.op)
                OP_NOP:   ok = it.ty == TY_NONE;
                OP_CONST: ok = !(it.ty == TY_BOOL && it.imm > 1) && wr(it.d, it.ty, it.imm);
                OP_MOVE:  ok = src_ok(it.a, it.ty) && wr(it.d, it.ty, va);
                OP_ADD, OP_SUB, OP_MUL:
                    ok = it.ty != TY_BOOL && binop(it.op, it.ty, it.d, it.a, it.b);
                OP_AND, OP_OR, OP_XOR, OP_EQ:
                    ok = binop(it.op, it.ty, it.d, it.a, it.b);
                OP_NOT:
                    ok = src_ok(it.a, it.ty) &&
                         wr(it.d, it.ty, it.ty == TY_BOOL ? {63'b0, va == 0} : ~va);
                OP_ULT: ok = it.ty == TY_U64 && binop(it.op, it.ty, it.d, it.a, it.b);
                OP_SLT: ok = it.ty == TY_I64 && binop(it.op, it.ty, it.d, it.a, it.b);
                OP_LOAD:
                    ok = frame_ok(it.imm) && scalar(it.ty) &&
                         !(it.ty == TY_BOOL && it.fw > 1) && wr(it.d, it.ty, it.fw);
                OP_STORE: begin
                    ok = frame_ok(it.imm) && src_ok(it.a, it.ty);
                    if (ok) begin
                        o.sen = 1;
                        o.soff = it.imm[31:0];
                        o.sdat = va;
                    end
                end
                OP_JUMP: begin
                    ok = it.ty == TY_NONE && it.imm < {32'b0, icount};
                    if (ok)
                        npc = it.imm[31:0];
                end
                OP_BRZ: begin
                    ok = src_ok(it.a, it.ty) && it.imm < {32'b0, icount};
                    if (ok && va == 0)
                        npc = it.imm[31:0];
                end
                OP_CONT: begin
                    ok = it.ty == TY_NONE && it.imm[63:32] == 0;
                    if (ok) begin
                        st = ST_CONT;
                        o.cont = it.imm[31:0];
                    end
                end
                OP_SUSP: begin
                    ok = it.ty == TY_NONE && it.a >= skf && it.a <= skl &&
                         it.imm[63:32] == 0 &&
                         (it.b == NO_PAYLOAD_REG || src_ok(it.b, TY_U64));
                    if (ok) begin
                        st = ST_SUSP;
                        o.kind = it.a;
                        o.cont = it.imm[31:0];
                        o.pay = (it.b == NO_PAYLOAD_REG) ? 64'd0 : vl[it.b[7:0]];
                    end
                end
                OP_TERM: begin
                    ok = it.ty == TY_NONE;
                    if (ok) begin
                        st = ST_TERM;
                        o.pay = it.imm;
                    end
                end
                default: ok = 0;
            endcase
            if (!ok) begin
                active = 0;
                o = '0;
                o.st = ST_BAD;
                pending_outcomes.push_back(o);
                return;
            end
            if (st != ST_RUN) begin
                active = 0;
            end else if (npc >= icount) begin
                active = 0;
                st = ST_BAD;
            end else begin
                pc = npc;
                o.npc = npc;
            end
            o.st = st;
            pending_outcomes.push_back(o);
        endfunction

        function void check(outcome_t got);
            outcome_t w;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d next_pc %0d", got.st, got.npc);
                return;
            end
            w = pending_outcomes.pop_front();
            if (got !== w) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d", results_seen);
                    $display("  want st=%0d pc=%h cont=%h kind=%h pay=%h se=%b so=%h sd=%h",
                             w.st, w.npc, w.cont, w.kind, w.pay, w.sen, w.soff, w.sdat);
                    $display("  got  st=%0d pc=%h cont=%h kind=%h pay=%h se=%b so=%h sd=%h",
                             got.st, got.npc, got.cont, got.kind, got.pay, got.sen,
                             got.soff, got.sdat);
                end
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_req_type = 0;
    logic [7:0]  s_opcode = 0;
    logic [7:0]  s_type_tag = 0;
    logic [15:0] s_dest_reg = 0;
    logic [15:0] s_src_a = 0;
    logic [15:0] s_src_b = 0;
    logic [63:0] s_immediate = 0;
    logic [63:0] s_frame_word = 0;
    logic        m_valid;
    logic        m_ready = 1;
    logic [2:0]  m_status;
    logic [31:0] m_next_pc;
    logic [31:0] m_continuation_out;
    logic [15:0] m_suspend_kind_out;
    logic [63:0] m_payload;
    logic        m_store_enable;
    logic [31:0] m_store_offset;
    logic [63:0] m_store_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    run_tracker sb = new();
    int tx_pct = 0;
    int rx_pct = 0;
    int quiet = 0;
    int n_items = 0;

    typed_register_bytecode_executor_top dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(negedge aclk)
        m_ready <= (rx_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check({m_status, m_next_pc, m_continuation_out, m_suspend_kind_out,
                      m_payload, m_store_enable, m_store_offset, m_store_data});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    function automatic int live_regs();
        return (sb.rcount > REG_DEPTH) ? REG_DEPTH : sb.rcount;
    endfunction

    // pick a register currently holding type t, or -1
    function automatic int find_reg(tag_t t);
        int n, s, k, i;
        n = live_regs();
        if (n == 0)
            return -1;
        s = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
            i = (s + k) % n;
            if (sb.tg[i] == t)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [63:0] frame_off();
        if (sb.flimit >= 8)
            return ($urandom_range(3) == 0) ? sb.flimit - 8 : $urandom_range(sb.flimit - 8);
        return $urandom_range(16);
    endfunction

    function automatic instr_t noise_item();
        instr_t it;
        it.req = $urandom_range(1);
        it.op = $urandom;
        it.ty = $urandom;
        it.d = $urandom;
        it.a = $urandom;
        it.b = $urandom;
        it.imm = r64();
        it.fw = r64();
        return it;
    endfunction

    // mostly legal instruction built from the current register file contents
    function automatic instr_t program_item();
        instr_t it;
        int n, ra, rb;
        tag_t t;
        it = '0;
        it.req = 1;
        n = live_regs();
        if (!sb.active) begin
            it.req = 0;
            case ($urandom_range(9))
                0: it.imm = r64();
                1: it.imm = sb.icount - 1;
                default: it.imm = $urandom_range(sb.icount - 1);
            endcase
            return it;
        end
        it.op = ($urandom_range(9) == 0) ? $urandom_range(OP_CONT, OP_TERM)
                                         : $urandom_range(OP_NOP, OP_BRZ);
        t = tag_t'($urandom_range(TY_U64, TY_BOOL));
        if ((it.op == OP_ADD || it.op == OP_SUB || it.op == OP_MUL) && t == TY_BOOL)
            t = TY_U64;
        if (it.op == OP_ULT)
            t = TY_U64;
        if (it.op == OP_SLT)
            t = TY_I64;
        it.ty = t;
        it.d = (n > 0) ? $urandom_range(n - 1) : 0;
        it.imm = r64();
        it.fw = r64();
        ra = find_reg(t);
        rb = find_reg(t);
        it.a = ra;
        it.b = rb;
        case (it.op)
            OP_NOP, OP_TERM: it.ty = TY_NONE;
            OP_JUMP: begin
                it.ty = TY_NONE;
                it.imm = $urandom_range(sb.icount - 1);
            end
            OP_CONT: begin
                it.ty = TY_NONE;
                it.imm = $urandom;
            end
            OP_SUSP: begin
                it.ty = TY_NONE;
                it.a = (sb.skf <= sb.skl) ? $urandom_range(sb.skl, sb.skf) : $urandom;
                rb = find_reg(TY_U64);
                it.b = ($urandom_range(1) == 0 || rb < 0) ? NO_PAYLOAD_REG : rb;
                it.imm = $urandom;
            end
            OP_LOAD: begin
                it.imm = frame_off();
                if (t == TY_BOOL)
                    it.fw = $urandom_range(1);
            end
            OP_STORE: it.imm = frame_off();
            OP_BRZ: it.imm = $urandom_range(sb.icount - 1);
            default: ;
        endcase
        // no source of the wanted type yet: create one
        if ((it.op inside {OP_MOVE, OP_NOT, OP_STORE, OP_BRZ} && ra < 0) ||
            (it.op inside {[OP_ADD:OP_XOR], [OP_EQ:OP_SLT]} && (ra < 0 || rb < 0)) ||
            it.op == OP_CONST) begin
            it.op = OP_CONST;
            it.ty = t;
            it.imm = (t == TY_BOOL) ? $urandom_range(1) : r64();
        end
        if ($urandom_range(29) == 0) begin
            case ($urandom_range(3))
                0: it.op = it.op ^ (8'd1 << $urandom_range(7));
                1: it.ty = $urandom;
                2: it.d = $urandom;
                default: it.imm = r64();
            endcase
        end
        return it;
    endfunction

    task automatic send(instr_t it);
        while ($urandom_range(99) < tx_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_req_type <= it.req;
        s_opcode <= it.op;
        s_type_tag <= it.ty;
        s_dest_reg <= it.d;
        s_src_a <= it.a;
        s_src_b <= it.b;
        s_immediate <= it.imm;
        s_frame_word <= it.fw;
        do @(posedge aclk); while (!s_ready);
        sb.note(it);
        n_items++;
        @(negedge aclk);
    endtask

    task automatic run_from(logic [63:0] pc);
        instr_t it;
        it = '0;
        it.imm = pc;
        send(it);
    endtask

    task automatic exec(logic [7:0] op, logic [7:0] ty, logic [15:0] d, logic [15:0] a,
                        logic [15:0] b, logic [63:0] imm, logic [63:0] fw);
        instr_t it;
        it = '{1'b1, op, ty, d, a, b, imm, fw};
        send(it);
    endtask

    // drop valid and hold until every result is back and the pipe has drained
    task automatic settle();
        s_valid <= 0;
        @(negedge aclk);
        while (sb.pending_outcomes.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [31:0] ic, logic [31:0] rc, logic [31:0] fl,
                             logic [31:0] kf, logic [31:0] kl);
        cfg_write(CFG_ICOUNT, ic);
        cfg_write(CFG_RCOUNT, rc);
        cfg_write(CFG_FLIMIT, fl);
        cfg_write(CFG_SKFIRST, kf);
        cfg_write(CFG_SKLAST, kl);
    endtask

    initial begin
        logic [31:0] ic, rc, fl, kf, kl;
        int p, k;
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed
        configure(100, 8, 64, 2, 5);
        run_from(100);
        exec(OP_NOP, TY_NONE, 0, 0, 0, 0, 0);
        run_from(0);
        exec(OP_CONST, TY_U64, 0, 0, 0, '1, 0);
        exec(OP_CONST, TY_U64, 1, 0, 0, 1, 0);
        exec(OP_ADD, TY_U64, 2, 0, 1, 0, 0);
        exec(OP_CONST, TY_I64, 3, 0, 0, 64'h8000_0000_0000_0000, 0);
        exec(OP_CONST, TY_I64, 4, 0, 0, 1, 0);
        exec(OP_SLT, TY_I64, 5, 3, 4, 0, 0);
        exec(OP_ULT, TY_U64, 6, 1, 0, 0, 0);
        exec(OP_MUL, TY_U64, 7, 0, 0, 0, 0);
        exec(OP_NOT, TY_BOOL, 5, 5, 0, 0, 0);
        exec(OP_BRZ, TY_BOOL, 0, 5, 0, 99, 0);
        exec(OP_STORE, TY_U64, 0, 0, 0, 56, 0);
        exec(OP_LOAD, TY_I64, 4, 0, 0, 57, '1);
        run_from(98);
        exec(OP_NOP, TY_NONE, 0, 0, 0, 0, 0);
        exec(OP_NOP, TY_NONE, 0, 0, 0, 0, 0);
        run_from(0);
        exec(OP_CONST, TY_U64, 8, 0, 0, 3, 0);
        run_from(5);
        exec(OP_SUSP, TY_NONE, 0, 5, NO_PAYLOAD_REG, 32'hFFFF_FFFF, 0);
        run_from(0);
        exec(OP_CONT, TY_NONE, 0, 0, 0, 64'h1_0000_0000, 0);
        run_from(0);
        exec(8'd200, TY_NONE, 0, 0, 0, 0, 0);
        run_from(0);
        exec(OP_TERM, TY_NONE, 0, 0, 0, '1, 0);
        run_from(50);
        settle();
        // shrink the program under a live run
        cfg_write(CFG_ICOUNT, 40);
        exec(OP_NOP, TY_NONE, 0, 0, 0, 0, 0);
        settle();

        // random phases
        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin ic = 1;              rc = 256; fl = 0;              kf = 0;  kl = 65535; end
                1: begin ic = 32'hFFFF_FFFF;  rc = 300 + $urandom_range(211);
                         fl = 32'hFFFF_FFFF;  kf = 3;   kl = 3; end
                2: begin ic = 24;             rc = (p == 2) ? 0 : 12; fl = 8;
                         kf = 10; kl = 2; end
                default: begin ic = $urandom_range(200, 2); rc = $urandom_range(16, 1);
                         fl = $urandom_range(300); kf = 0; kl = 0; end
            endcase
            if (p >= 4) begin
                kf = $urandom_range(65535);
                kl = $urandom_range(65535);
            end
            configure(ic, rc, fl, kf, kl);
            case (p % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 48; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 48; end
                default: begin tx_pct = 15; rx_pct = 15; end
            endcase
            for (k = 0; k < 105; k++) begin
                if (p == 2 && k == 50) begin
                    s_valid <= 0;
                    @(negedge aclk);
                    while (sb.pending_outcomes.size() != 0)
                        @(negedge aclk);
                end
                send(($urandom_range(19) == 0) ? noise_item() : program_item());
            end
            settle();
        end
        tx_pct = 0;
        rx_pct = 0;

        $display("Sent %0d requests over 8 configurations and 4 idling patterns;", n_items);
        $display("checked %0d results, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/trbe_pkg.sv
src/trbe_ram.sv
src/typed_register_bytecode_executor_top.sv
test/tb.sv
